@@ hw/rtl/sbcc_pkg.sv @@
// Package for the sprite blitter with clipping and color key.
// Holds the item structs, the configuration struct and the register indexes.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package sbcc_pkg;

    // Index of each configuration register on the write port.
    typedef enum logic [2:0] {
        REG_SPRITE_WIDTH  = 3'd0,
        REG_SPRITE_HEIGHT = 3'd1,
        REG_POS_X         = 3'd2,
        REG_POS_Y         = 3'd3,
        REG_FRAME_SELECT  = 3'd4,
        REG_KEY_COLOR     = 3'd5
    } t_reg_index;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int ADDR_W      = 13;
    localparam int COLOR_W     = 16;
    localparam int COUNT_W     = 8;
    localparam int POS_W       = 9;

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0] RST_SPRITE_WIDTH  = 8'd8;
    localparam logic [COUNT_W-1:0] RST_SPRITE_HEIGHT = 8'd8;

    // One sheet pixel as it enters the block.
    typedef struct packed {
        logic [COLOR_W-1:0] pixel;
        logic               sheet_start;
    } t_in_item;

    // One framebuffer write as it leaves the block.
    typedef struct packed {
        logic [ADDR_W-1:0]  dest_addr;
        logic [COLOR_W-1:0] color;
    } t_out_item;

    // Configuration registers; pos_x and pos_y are two's complement.
    typedef struct packed {
        logic [COUNT_W-1:0] sprite_width;
        logic [COUNT_W-1:0] sprite_height;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [COUNT_W-1:0] frame_select;
        logic [COLOR_W-1:0] key_color;
    } t_cfg;

    // Result of the per-pixel test: write or not, and the clipped screen spot.
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] sx;
        logic [POS_W-1:0] sy;
    } t_hit;

endpackage

@@ hw/rtl/sbcc_track.sv @@
// Column, row and frame tracking plus the per-pixel write test.
// Depends on sbcc_pkg for the item, configuration and test-result structs.
`timescale 1ns / 1ps

module sbcc_track
    import sbcc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_hit     o_hit
);

    localparam int CMP_W = 11;

    logic [COUNT_W-1:0] r_col, r_row, r_frame;
    logic [COUNT_W-1:0] n_col, n_row, n_frame;
    logic [COUNT_W-1:0] col_eff, row_eff, frame_eff;
    logic [COUNT_W-1:0] col_inc, row_inc;
    logic [COUNT_W-1:0] width_eff, height_eff;
    logic [POS_W:0]     sx, sy;
    logic               on_frame, on_screen, opaque;

    // A sheet start puts this pixel at column 0, row 0, frame 0.
    assign col_eff   = i_item.sheet_start ? '0 : r_col;
    assign row_eff   = i_item.sheet_start ? '0 : r_row;
    assign frame_eff = i_item.sheet_start ? '0 : r_frame;

    // Screen position, 10-bit two's complement; range is -256 to 510.
    assign sx = {i_cfg.pos_x[POS_W-1], i_cfg.pos_x} + {2'b00, col_eff};
    assign sy = {i_cfg.pos_y[POS_W-1], i_cfg.pos_y} + {2'b00, row_eff};

    // Write test: right frame, inside the screen, not the key color.
    assign on_frame  = (frame_eff == i_cfg.frame_select);
    assign on_screen = !sx[POS_W] && !sy[POS_W]
                    && ({2'b00, sx[POS_W-1:0]} < CMP_W'(SCREEN_WIDTH))
                    && ({2'b00, sy[POS_W-1:0]} < CMP_W'(SCREEN_HEIGHT));
    assign opaque    = (i_cfg.key_color == '0) || (i_item.pixel != i_cfg.key_color);

    assign o_hit.hit = on_frame && on_screen && opaque;
    assign o_hit.sx  = sx[POS_W-1:0];
    assign o_hit.sy  = sy[POS_W-1:0];

    // Next position: a zero size acts as one, a count past the size wraps.
    assign width_eff  = (i_cfg.sprite_width  == '0) ? COUNT_W'(1) : i_cfg.sprite_width;
    assign height_eff = (i_cfg.sprite_height == '0) ? COUNT_W'(1) : i_cfg.sprite_height;
    assign col_inc    = col_eff + COUNT_W'(1);
    assign row_inc    = row_eff + COUNT_W'(1);

    always_comb begin
        n_col   = col_inc;
        n_row   = row_eff;
        n_frame = frame_eff;
        if (col_inc == '0 || col_inc >= width_eff) begin
            n_col = '0;
            n_row = row_inc;
            if (row_inc == '0 || row_inc >= height_eff) begin
                n_row   = '0;
                n_frame = frame_eff + COUNT_W'(1);
            end
        end
    end

    // Position counters advance once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_frame <= '0;
        end else if (i_adv) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_frame <= n_frame;
        end
    end

endmodule

@@ hw/rtl/sprite_blit_clip_colorkey.sv @@
// Top level of the sprite blitter with clipping and color key.
// Depends on sbcc_pkg and sbcc_track.
//
//   channel   direction   handshake                    payload
//   in        input       i_in_valid / o_in_ready      i_in_item  (t_in_item)
//   out       output      o_out_valid / i_out_ready    o_out_item (t_out_item)
//   cfg       input       i_cfg_wr_en                  i_cfg_index, i_cfg_data
//
// One item is accepted per cycle when the output side keeps up.
// A drawn pixel goes from the test register through the address multiply into
// the output register, which drives o_out_item.
// Skipped pixels cause no result and hold no pipeline slot.
// Reset is synchronous; it resets the counters and configuration registers and clears all valids.
// A stalled output backs up into the test register before o_in_ready drops.
`timescale 1ns / 1ps

module sprite_blit_clip_colorkey
    import sbcc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam bit ADDR_FITS = (SCREEN_WIDTH * SCREEN_HEIGHT) <= (2 ** ADDR_W);

    t_cfg               r_cfg;
    t_hit               hit;
    logic               in_accept;
    logic               s1_ready, out_ready;
    logic               r_s1_valid;
    logic [POS_W-1:0]   r_s1_sx, r_s1_sy;
    logic [COLOR_W-1:0] r_s1_color;
    logic [ADDR_W-1:0]  row_base, addr;
    logic               r_out_valid;
    t_out_item          r_out_item;

    // Configuration registers; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sprite_width  <= RST_SPRITE_WIDTH;
            r_cfg.sprite_height <= RST_SPRITE_HEIGHT;
            r_cfg.pos_x         <= '0;
            r_cfg.pos_y         <= '0;
            r_cfg.frame_select  <= '0;
            r_cfg.key_color     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_SPRITE_WIDTH:  r_cfg.sprite_width  <= i_cfg_data[COUNT_W-1:0];
                REG_SPRITE_HEIGHT: r_cfg.sprite_height <= i_cfg_data[COUNT_W-1:0];
                REG_POS_X:         r_cfg.pos_x         <= i_cfg_data[POS_W-1:0];
                REG_POS_Y:         r_cfg.pos_y         <= i_cfg_data[POS_W-1:0];
                REG_FRAME_SELECT:  r_cfg.frame_select  <= i_cfg_data[COUNT_W-1:0];
                REG_KEY_COLOR:     r_cfg.key_color     <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Flow control: each stage loads when it is empty or its item moves on.
    assign out_ready  = !r_out_valid || i_out_ready;
    assign s1_ready   = !r_s1_valid || out_ready;
    assign o_in_ready = s1_ready;
    assign in_accept  = i_in_valid && s1_ready;

    sbcc_track #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (in_accept),
        .i_item  (i_in_item),
        .i_cfg   (r_cfg),
        .o_hit   (hit)
    );

    // Test register: only pixels that are drawn take a slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid && hit.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_sx    <= hit.sx;
            r_s1_sy    <= hit.sy;
            r_s1_color <= i_in_item.pixel;
        end
    end

    // Linear address, row times screen width plus column, modulo 2^13.
    assign row_base = {{(ADDR_W-POS_W){1'b0}}, r_s1_sy} * ADDR_W'(SCREEN_WIDTH);
    assign addr     = row_base + {{(ADDR_W-POS_W){1'b0}}, r_s1_sx};

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_out_item.dest_addr <= addr;
            r_out_item.color     <= r_s1_color;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A result never carries the key color while a key is set.
    a_key_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_cfg.key_color != '0) |-> (o_out_item.color != r_cfg.key_color))
        else $error("key-colored pixel reached the output");

    // When the screen fits the address space, every address lies on it.
    a_addr_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ADDR_FITS)
            |-> (int'(o_out_item.dest_addr) < SCREEN_WIDTH * SCREEN_HEIGHT))
        else $error("framebuffer address outside the screen");

    // A held test-register item is not lost while the output stalls.
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_ready) |=> (r_s1_valid && $stable(r_s1_sx) && $stable(r_s1_sy)))
        else $error("stalled item dropped from the test register");

    // Input is refused only when both stages are full and the output stalls.
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_out_valid && !i_out_ready))
        else $error("input refused with room in the pipeline");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule
